>>> hw/rtl/dsrs_pkg.sv
// Shared types and constants for the device score rank sorter.
// Holds the configuration record, the queue item, the sorter state, register codes and sizes.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package dsrs_pkg;

    // Capacity of the sorted chain and the cap applied to sighting counts.
    localparam int MAX_ENTRIES  = 32;
    localparam int SIGHTING_CAP = 5;

    // Widths; INDEX_W and SCORE_W are fixed, the others are derived.
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int INDEX_W = 5;
    localparam int EXT_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int CAP_W   = $clog2(SIGHTING_CAP + 1);
    localparam int SCORE_W = 8;

    // Depth of the queue between scoring and sorting (a power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port geometry.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_STRONG_THR  = 3'd0,
        REG_MEDIUM_THR  = 3'd1,
        REG_STRONG_PTS  = 3'd2,
        REG_MEDIUM_PTS  = 3'd3,
        REG_SIGHT_MULT  = 3'd4,
        REG_HIDDEN_PTS  = 3'd5,
        REG_CAMERA_PTS  = 3'd6,
        REG_CEILING     = 3'd7
    } cfg_addr_t;

    // Current scoring configuration.
    typedef struct packed {
        logic signed [7:0] strong_thr;
        logic signed [7:0] medium_thr;
        logic [7:0]        strong_pts;
        logic [7:0]        medium_pts;
        logic [7:0]        sight_mult;
        logic [7:0]        hidden_pts;
        logic [7:0]        camera_pts;
        logic [7:0]        ceiling;
    } cfg_t;

    // One scored record on its way to the sorter.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               last;
    } score_item_t;

    // Sorter control state.
    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/dsrs_cfg.sv
// Configuration register bank behind the APB-style port.
// Depends on dsrs_pkg for the register codes and the configuration record.
`default_nettype none

module dsrs_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dsrs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dsrs_pkg::PDATA_W-1:0] pwdata,
    output logic      [dsrs_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output dsrs_pkg::cfg_t                    cfg
);

    dsrs_pkg::cfg_t      cfg_reg;
    dsrs_pkg::cfg_t      cfg_next;
    dsrs_pkg::cfg_addr_t reg_sel;
    logic                wr_en;
    logic [7:0]          rd_byte;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign reg_sel = dsrs_pkg::cfg_addr_t'(paddr[dsrs_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                dsrs_pkg::REG_STRONG_THR: cfg_next.strong_thr = pwdata[7:0];
                dsrs_pkg::REG_MEDIUM_THR: cfg_next.medium_thr = pwdata[7:0];
                dsrs_pkg::REG_STRONG_PTS: cfg_next.strong_pts = pwdata[7:0];
                dsrs_pkg::REG_MEDIUM_PTS: cfg_next.medium_pts = pwdata[7:0];
                dsrs_pkg::REG_SIGHT_MULT: cfg_next.sight_mult = pwdata[7:0];
                dsrs_pkg::REG_HIDDEN_PTS: cfg_next.hidden_pts = pwdata[7:0];
                dsrs_pkg::REG_CAMERA_PTS: cfg_next.camera_pts = pwdata[7:0];
                dsrs_pkg::REG_CEILING:    cfg_next.ceiling    = pwdata[7:0];
            endcase
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_sel)
            dsrs_pkg::REG_STRONG_THR: rd_byte = cfg_reg.strong_thr;
            dsrs_pkg::REG_MEDIUM_THR: rd_byte = cfg_reg.medium_thr;
            dsrs_pkg::REG_STRONG_PTS: rd_byte = cfg_reg.strong_pts;
            dsrs_pkg::REG_MEDIUM_PTS: rd_byte = cfg_reg.medium_pts;
            dsrs_pkg::REG_SIGHT_MULT: rd_byte = cfg_reg.sight_mult;
            dsrs_pkg::REG_HIDDEN_PTS: rd_byte = cfg_reg.hidden_pts;
            dsrs_pkg::REG_CAMERA_PTS: rd_byte = cfg_reg.camera_pts;
            dsrs_pkg::REG_CEILING:    rd_byte = cfg_reg.ceiling;
        endcase
    end

    assign prdata = dsrs_pkg::PDATA_W'(rd_byte);
    assign cfg    = cfg_reg;

    // Register bank with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strong_thr <= -8'sd60;
            cfg_reg.medium_thr <= -8'sd75;
            cfg_reg.strong_pts <= 8'd3;
            cfg_reg.medium_pts <= 8'd1;
            cfg_reg.sight_mult <= 8'd1;
            cfg_reg.hidden_pts <= 8'd1;
            cfg_reg.camera_pts <= 8'd5;
            cfg_reg.ceiling    <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dsrs_front.sv
// Front end: accepts device records and computes their 8-bit scores.
// Depends on dsrs_pkg for the configuration record and the queue item type.
`default_nettype none

module dsrs_front (
    input  wire logic                  push,
    input  wire logic                  q_full,
    input  wire logic                  whitelisted,
    input  wire logic signed [7:0]     signal_strength,
    input  wire logic                  random_address,
    input  wire logic [15:0]           sighting_count,
    input  wire logic                  name_empty,
    input  wire logic                  camera_vendor,
    input  wire logic                  last_record,
    input  wire dsrs_pkg::cfg_t        cfg,
    output logic                       q_write,
    output dsrs_pkg::score_item_t      q_item
);

    logic [dsrs_pkg::CAP_W-1:0]     seen;
    logic [dsrs_pkg::CAP_W+7:0]     sight_prod;
    logic [7:0]                     signal_pts;
    logic [7:0]                     sight_pts;
    logic [7:0]                     raw_sum;
    logic [7:0]                     score_val;

    // A transaction is taken whenever the queue has room.
    assign q_write = push && !q_full;

    // Tiered signal points: the strong test wins when both hold.
    always_comb
    begin
        priority if ($signed(signal_strength) > $signed(cfg.strong_thr))
            signal_pts = cfg.strong_pts;
        else if ($signed(signal_strength) > $signed(cfg.medium_thr))
            signal_pts = cfg.medium_pts;
        else
            signal_pts = 8'd0;
    end

    // Capped sightings times the multiplier, only for fixed addresses.
    assign seen = (sighting_count > 16'(dsrs_pkg::SIGHTING_CAP))
                ? dsrs_pkg::CAP_W'(dsrs_pkg::SIGHTING_CAP)
                : sighting_count[dsrs_pkg::CAP_W-1:0];
    assign sight_prod = (dsrs_pkg::CAP_W+8)'(seen) * (dsrs_pkg::CAP_W+8)'(cfg.sight_mult);
    assign sight_pts  = random_address ? 8'd0 : sight_prod[7:0];

    // The sum wraps at 256, then the ceiling applies.
    assign raw_sum = signal_pts + sight_pts
                   + (name_empty    ? cfg.hidden_pts : 8'd0)
                   + (camera_vendor ? cfg.camera_pts : 8'd0);

    always_comb
    begin
        priority if (whitelisted)
            score_val = 8'd0;
        else if (raw_sum > cfg.ceiling)
            score_val = cfg.ceiling;
        else
            score_val = raw_sum;
    end

    assign q_item.score = score_val;
    assign q_item.last  = last_record;

endmodule

`default_nettype wire

>>> hw/rtl/dsrs_queue.sv
// Short FIFO of scored records between the front end and the sorter.
// Depends on dsrs_pkg for the item type and the queue depth.
`default_nettype none

module dsrs_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire dsrs_pkg::score_item_t wr_item,
    output logic                       full,
    input  wire logic                  rd_en,
    output logic                       rd_valid,
    output dsrs_pkg::score_item_t      rd_item
);

    dsrs_pkg::score_item_t              slot_reg [dsrs_pkg::QUEUE_DEPTH];
    logic [dsrs_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [dsrs_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [dsrs_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [dsrs_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [dsrs_pkg::QCNT_W-1:0]        fill_reg;
    logic [dsrs_pkg::QCNT_W-1:0]        fill_next;

    assign full     = (fill_reg == dsrs_pkg::QCNT_W'(dsrs_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];

    // Pointers wrap naturally since the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + dsrs_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + dsrs_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en && !rd_en)
            fill_next = fill_reg + dsrs_pkg::QCNT_W'(1);
        else if (rd_en && !wr_en)
            fill_next = fill_reg - dsrs_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

>>> hw/rtl/dsrs_back.sv
// Back end: sorted shift chain with stable insertion and ranked emission.
// Depends on dsrs_pkg for sizes, the item type and the state enum.
`default_nettype none

module dsrs_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire dsrs_pkg::score_item_t         q_item,
    output logic                               q_pop,
    output logic [dsrs_pkg::INDEX_W-1:0]       entry_index,
    output logic [dsrs_pkg::SCORE_W-1:0]       score,
    output logic                               last_result,
    output logic                               empty,
    input  wire logic                          pop
);

    localparam int N = dsrs_pkg::MAX_ENTRIES;

    dsrs_pkg::back_state_t            state_reg;
    dsrs_pkg::back_state_t            state_next;
    logic [dsrs_pkg::CNT_W-1:0]       count_reg;
    logic [dsrs_pkg::CNT_W-1:0]       count_next;
    logic [dsrs_pkg::SCORE_W-1:0]     cell_score_reg [N];
    logic [dsrs_pkg::SCORE_W-1:0]     cell_score_next [N];
    logic [dsrs_pkg::INDEX_W-1:0]     cell_index_reg [N];
    logic [dsrs_pkg::INDEX_W-1:0]     cell_index_next [N];
    logic [dsrs_pkg::SCORE_W-1:0]     up_score [N];
    logic [dsrs_pkg::INDEX_W-1:0]     up_index [N];
    logic [dsrs_pkg::SCORE_W-1:0]     down_score [N];
    logic [dsrs_pkg::INDEX_W-1:0]     down_index [N];
    logic [N-1:0]                     keep;
    logic [N-1:0]                     keep_ext;
    logic [dsrs_pkg::EXT_W-1:0]       count_ext;
    logic [dsrs_pkg::INDEX_W-1:0]     new_index;
    logic                             do_insert;
    logic                             do_emit;
    logic                             out_free;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [dsrs_pkg::INDEX_W-1:0]     out_index_reg;
    logic [dsrs_pkg::SCORE_W-1:0]     out_score_reg;
    logic                             out_last_reg;
    logic                             sorted_ok;

    // Handshake with the queue and the output register.
    assign out_free  = !out_valid_reg || pop;
    assign q_pop     = (state_reg == dsrs_pkg::ST_FILL) && q_valid;
    assign do_insert = q_pop && (count_reg < dsrs_pkg::CNT_W'(N));
    assign do_emit   = (state_reg == dsrs_pkg::ST_EMIT) && out_free;

    // Arrival index of a new record is the fill count, masked to the index width.
    assign count_ext = dsrs_pkg::EXT_W'(count_reg);
    assign new_index = count_ext[dsrs_pkg::INDEX_W-1:0];

    // Cells that hold a score at least as large as the new one stay put.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            keep[i] = (dsrs_pkg::CNT_W'(i) < count_reg) && (cell_score_reg[i] >= q_item.score);
        end
        keep_ext = {keep[N-2:0], 1'b1};
    end

    // Neighbor values for shifting down on insertion and up on emission.
    always_comb
    begin
        up_score[0]       = q_item.score;
        up_index[0]       = new_index;
        down_score[N-1]   = cell_score_reg[N-1];
        down_index[N-1]   = cell_index_reg[N-1];
        for (int i = 1; i < N; i++)
        begin
            up_score[i]     = cell_score_reg[i-1];
            up_index[i]     = cell_index_reg[i-1];
            down_score[i-1] = cell_score_reg[i];
            down_index[i-1] = cell_index_reg[i];
        end
    end

    // Per-cell update of the chain.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cell_score_next[i] = cell_score_reg[i];
            cell_index_next[i] = cell_index_reg[i];
            if (do_insert && !keep[i])
            begin
                if (keep_ext[i])
                begin
                    cell_score_next[i] = q_item.score;
                    cell_index_next[i] = new_index;
                end
                else
                begin
                    cell_score_next[i] = up_score[i];
                    cell_index_next[i] = up_index[i];
                end
            end
            else if (do_emit)
            begin
                cell_score_next[i] = down_score[i];
                cell_index_next[i] = down_index[i];
            end
        end
    end

    // Fill count, state and output register valid.
    always_comb
    begin
        count_next     = count_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b0;
        unique case (state_reg)
            dsrs_pkg::ST_FILL:
            begin
                if (do_insert)
                    count_next = count_reg + dsrs_pkg::CNT_W'(1);
                if (q_pop && q_item.last)
                    state_next = dsrs_pkg::ST_EMIT;
            end
            dsrs_pkg::ST_EMIT:
            begin
                if (do_emit)
                begin
                    count_next     = count_reg - dsrs_pkg::CNT_W'(1);
                    out_valid_next = 1'b1;
                    if (count_reg == dsrs_pkg::CNT_W'(1))
                        state_next = dsrs_pkg::ST_FILL;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsrs_pkg::ST_FILL;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Chain cells and result payload need no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            cell_score_reg[i] <= cell_score_next[i];
            cell_index_reg[i] <= cell_index_next[i];
        end
        if (do_emit)
        begin
            out_score_reg <= cell_score_reg[0];
            out_index_reg <= cell_index_reg[0];
            out_last_reg  <= (count_reg == dsrs_pkg::CNT_W'(1));
        end
    end

    assign entry_index = out_index_reg;
    assign score       = out_score_reg;
    assign last_result = out_last_reg;
    assign empty       = !out_valid_reg;

    // Occupied cells must be in non-increasing score order.
    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 1; i < N; i++)
        begin
            if ((dsrs_pkg::CNT_W'(i) < count_reg) && (cell_score_reg[i] > cell_score_reg[i-1]))
                sorted_ok = 1'b0;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dsrs_pkg::CNT_W'(N))
        else $error("sorter fill count beyond capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsrs_pkg::ST_EMIT |-> count_reg != '0)
        else $error("emission with an empty chain");

    a_no_pop_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsrs_pkg::ST_EMIT |-> !q_pop)
        else $error("queue read during emission");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("sorted chain out of order");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        do_emit && count_reg == dsrs_pkg::CNT_W'(1) |=> state_reg == dsrs_pkg::ST_FILL
            && count_reg == '0)
        else $error("run did not close after its final result");

endmodule

`default_nettype wire

>>> hw/rtl/device_score_rank_sorter_core.sv
// Device score rank sorter: one record accepted per cycle while the queue has room.
// The last record is queued and inserted into the chain before results are output.
// Emission gives one result per cycle while results are popped; the sorter then
// takes no records and the four-entry queue fills, then full stalls the input.
// Reset clears the fill count, queue, control state and loads the register defaults.
// Depends on dsrs_pkg, dsrs_cfg, dsrs_front, dsrs_queue and dsrs_back.
`default_nettype none

module device_score_rank_sorter_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input queue side
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic                                  whitelisted,
    input  wire logic signed [7:0]                     signal_strength,
    input  wire logic                                  random_address,
    input  wire logic [15:0]                           sighting_count,
    input  wire logic                                  name_empty,
    input  wire logic                                  camera_vendor,
    input  wire logic                                  last_record,
    // Result queue side
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic [dsrs_pkg::INDEX_W-1:0]               entry_index,
    output logic [dsrs_pkg::SCORE_W-1:0]               score,
    output logic                                       last_result,
    // Configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [dsrs_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [dsrs_pkg::PDATA_W-1:0]          pwdata,
    output logic      [dsrs_pkg::PDATA_W-1:0]          prdata,
    output logic                                       pready
);

    dsrs_pkg::cfg_t         cfg;
    dsrs_pkg::score_item_t  wr_item;
    dsrs_pkg::score_item_t  rd_item;
    logic                   q_write;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;

    // Register bank.
    dsrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Scoring front end.
    dsrs_front u_front (
        .push            (push),
        .q_full          (q_full),
        .whitelisted     (whitelisted),
        .signal_strength (signal_strength),
        .random_address  (random_address),
        .sighting_count  (sighting_count),
        .name_empty      (name_empty),
        .camera_vendor   (camera_vendor),
        .last_record     (last_record),
        .cfg             (cfg),
        .q_write         (q_write),
        .q_item          (wr_item)
    );

    // Decoupling queue.
    dsrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_write),
        .wr_item  (wr_item),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (rd_item)
    );

    // Sorting back end.
    dsrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (rd_item),
        .q_pop       (q_pop),
        .entry_index (entry_index),
        .score       (score),
        .last_result (last_result),
        .empty       (empty),
        .pop         (pop)
    );

    assign full = q_full;

endmodule

`default_nettype wire
